/* sv/imh_pkg.sv */
// package for the indexed min heap: opcodes, status codes, sequencer states, entry compare
// used by the heap top level and the testbench

package imh_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_SPACE_DEF = 1024;
    localparam int KEY_W   = 10;
    localparam int PRIO_W  = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP_TOP = 3'd1,
        OP_POP_KEY = 3'd2,
        OP_GET     = 3'd3,
        OP_UPDATE  = 3'd4
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOOK,      // key table read issued
        S_LOOK_W,    // key table data valid
        S_RD_S,      // read slot s
        S_RD_S_W,
        S_MOVE,      // move last into s
        S_PUSH_CHK,  // key table read for push key
        S_PUSH_CHK_W,
        S_PUSH_WR,   // write new entry at end
        S_UP_RD,     // read parent of cur
        S_UP_W,
        S_DN_RD,     // read left child
        S_DN_RD2,    // read right child
        S_DN_W,
        S_SWAP2,     // second half of a swap
        S_OUT
    } state_t;

    // true when entry a ranks below entry b
    function automatic logic ranks_below(input logic [2*PRIO_W-1:0] a,
                                         input logic [2*PRIO_W-1:0] b);
        logic signed [PRIO_W-1:0] ma, mb, na, nb;
        begin
            ma = a[2*PRIO_W-1:PRIO_W];
            mb = b[2*PRIO_W-1:PRIO_W];
            na = a[PRIO_W-1:0];
            nb = b[PRIO_W-1:0];
            if (ma != mb) ranks_below = ma > mb;
            else          ranks_below = na < nb;
        end
    endfunction

endpackage

/* sv/indexed_min_heap.sv */
// top level of the indexed min heap: sequencer over slot and key tables held in rams
// depends on imh_pkg and imh_ram
//
//  channel | dir | fields (tdata from lsb)
//  s_axis  | in  | kind, target_key, item_key, prio_major, prio_minor
//  m_axis  | out | status, out_key, out_major, out_minor, count
//
// one item at a time; an empty pop, a missing key or a rejected push ends without
// touching the slot table. push writes the new entry at the end and climbs; removal
// moves the last entry into the freed slot, then climbs or descends (each level is
// slot ram reads, a compare and the swap writes); update does a removal, then a push.
// after reset a clearing pass empties the key table; no item is taken meanwhile.
// the result register holds while m_axis_tready is low.

module indexed_min_heap #(
    parameter int CAPACITY  = imh_pkg::CAPACITY_DEF,
    parameter int KEY_SPACE = imh_pkg::KEY_SPACE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[2:0], target_key[12:3], item_key[22:13], prio_major[54:23], prio_minor[86:55]
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], out_key[12:3], out_major[44:13], out_minor[76:45], count[87:77]
    output logic [87:0]  m_axis_tdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int KW = $clog2(KEY_SPACE);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 2 * imh_pkg::PRIO_W + imh_pkg::KEY_W;  // prios and key
    localparam int TW = SW + 1;                               // valid and slot

    typedef logic [SW-1:0] slot_t;

    imh_pkg::state_t state_reg, state_next;

    // latched item
    logic [2:0]                 kind_reg;
    logic [imh_pkg::KEY_W-1:0]  tkey_reg, ikey_reg;
    logic [2*imh_pkg::PRIO_W-1:0] iprio_reg;
    logic [2:0]                 status_reg, status_next;
    logic [EW-1:0]              oent_reg, oent_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    slot_t                      cur_reg, cur_next;
    logic [EW-1:0]              ca_reg, ca_next, cb_reg, cb_next;
    logic                       pushing_reg, pushing_next;
    logic                       ins_reg, ins_next;
    logic                       clr_reg;
    logic [KW:0]                clr_cnt_reg;
    logic                       res_valid_reg;
    logic [87:0]                res_reg;

    // ram ports
    logic          s_we;
    slot_t         s_waddr, s_raddr;
    logic [EW-1:0] s_wdata, s_rdata;
    logic          k_we;
    logic [KW-1:0] k_waddr, k_raddr;
    logic [TW-1:0] k_wdata, k_rdata;

    imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slots (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));

    imh_ram #(.WIDTH(TW), .DEPTH(KEY_SPACE)) u_keys (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata));

    // input fields
    logic [2:0]                in_kind;
    logic [imh_pkg::KEY_W-1:0] in_tkey, in_ikey;
    assign in_kind = s_axis_tdata[2:0];
    assign in_tkey = s_axis_tdata[12:3];
    assign in_ikey = s_axis_tdata[22:13];

    logic accept;
    assign s_axis_tready = (state_reg == imh_pkg::S_IDLE) && !clr_reg && !res_valid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    // key range checks
    function automatic logic key_ok(input logic [imh_pkg::KEY_W-1:0] k);
        key_ok = 32'(k) < KEY_SPACE;
    endfunction

    logic [KW-1:0] tkey_i, ikey_i;
    assign tkey_i = KW'(tkey_reg);
    assign ikey_i = KW'(ikey_reg);

    slot_t last_slot, par_slot;
    logic [SW:0] lchild, rchild;
    assign last_slot = SW'(cnt_reg - CW'(1));
    assign par_slot  = SW'((cur_reg - slot_t'(1)) >> 1);
    assign lchild    = {cur_reg, 1'b1};
    assign rchild    = {cur_reg, 1'b0} + (SW+1)'(2);

    logic [2*imh_pkg::PRIO_W-1:0] pa, pb, pc;
    assign pa = ca_reg[EW-1:imh_pkg::KEY_W];
    assign pb = cb_reg[EW-1:imh_pkg::KEY_W];
    assign pc = s_rdata[EW-1:imh_pkg::KEY_W];

    imh_pkg::state_t ovr_state;
    logic            ovr_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imh_pkg::S_IDLE:      if (accept) state_next = imh_pkg::S_LOOK;
            imh_pkg::S_LOOK:      state_next = imh_pkg::S_LOOK_W;
            imh_pkg::S_LOOK_W:    state_next = imh_pkg::S_OUT;
            imh_pkg::S_RD_S:      state_next = imh_pkg::S_RD_S_W;
            imh_pkg::S_RD_S_W:    state_next = imh_pkg::S_MOVE;
            imh_pkg::S_MOVE:      state_next = imh_pkg::S_OUT;
            imh_pkg::S_PUSH_CHK:  state_next = imh_pkg::S_PUSH_CHK_W;
            imh_pkg::S_PUSH_CHK_W: state_next = imh_pkg::S_OUT;
            imh_pkg::S_PUSH_WR:   state_next = imh_pkg::S_UP_RD;
            imh_pkg::S_UP_RD:     state_next = imh_pkg::S_UP_W;
            imh_pkg::S_UP_W:      state_next = imh_pkg::S_OUT;
            imh_pkg::S_DN_RD:     state_next = imh_pkg::S_DN_RD2;
            imh_pkg::S_DN_RD2:    state_next = imh_pkg::S_DN_W;
            imh_pkg::S_DN_W:      state_next = imh_pkg::S_OUT;
            imh_pkg::S_SWAP2:     state_next = imh_pkg::S_OUT;
            imh_pkg::S_OUT:       state_next = imh_pkg::S_IDLE;
            default:              state_next = imh_pkg::S_IDLE;
        endcase
        // datapath block overrides the exit of the work states
        if (ovr_valid)
            state_next = ovr_state;
    end

    // datapath and ram control
    always_comb
    begin
        logic lb, rb;
        ovr_valid    = 1'b0;
        ovr_state    = imh_pkg::S_IDLE;
        status_next  = status_reg;
        oent_next    = oent_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        pushing_next = pushing_reg;
        ins_next     = ins_reg;
        s_we = 1'b0; s_waddr = cur_reg; s_wdata = ca_reg; s_raddr = cur_reg;
        k_we = 1'b0; k_waddr = tkey_i; k_wdata = '0; k_raddr = tkey_i;
        lb = 1'b0; rb = 1'b0;
        if (clr_reg)
        begin
            k_we = 1'b1;
            k_waddr = clr_cnt_reg[KW-1:0];
        end
        unique case (state_reg)
            imh_pkg::S_IDLE:
            begin
                status_next  = imh_pkg::ST_OK;
                oent_next    = '0;
                pushing_next = 1'b0;
                ins_next     = 1'b0;
                k_raddr      = KW'(in_tkey);
                if (accept && in_kind == imh_pkg::OP_PUSH)
                    k_raddr = KW'(in_ikey);
                s_raddr = '0;
            end
            imh_pkg::S_LOOK:
            begin
                k_raddr = tkey_i;
                s_raddr = '0;
                if (kind_reg == imh_pkg::OP_PUSH)
                begin
                    ovr_valid = 1'b1;
                    if (!key_ok(ikey_reg))
                    begin
                        status_next = imh_pkg::ST_NOT_FOUND;
                        ovr_state = imh_pkg::S_OUT;
                    end
                    else
                    begin
                        k_raddr = ikey_i;
                        ovr_state = imh_pkg::S_PUSH_CHK_W;
                    end
                end
                else if (kind_reg == imh_pkg::OP_POP_TOP)
                begin
                    ovr_valid = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        status_next = imh_pkg::ST_EMPTY;
                        ovr_state = imh_pkg::S_OUT;
                    end
                    else
                    begin
                        cur_next = '0;
                        s_raddr = '0;
                        ovr_state = imh_pkg::S_RD_S_W;
                    end
                end
                else if (!(kind_reg == imh_pkg::OP_POP_KEY || kind_reg == imh_pkg::OP_GET
                           || kind_reg == imh_pkg::OP_UPDATE))
                begin
                    ovr_valid = 1'b1;
                    ovr_state = imh_pkg::S_OUT;
                end
            end
            imh_pkg::S_LOOK_W:
            begin
                ovr_valid = 1'b1;
                if (!key_ok(tkey_reg) || !k_rdata[SW] ||
                    (kind_reg == imh_pkg::OP_UPDATE && !key_ok(ikey_reg)))
                begin
                    status_next = imh_pkg::ST_NOT_FOUND;
                    ovr_state = imh_pkg::S_OUT;
                end
                else
                begin
                    cur_next = k_rdata[SW-1:0];
                    s_raddr  = k_rdata[SW-1:0];
                    ovr_state = imh_pkg::S_RD_S_W;
                end
            end
            imh_pkg::S_RD_S_W:
            begin
                // entry at cur is on the read port
                oent_next = s_rdata;
                s_raddr   = last_slot;
                if (kind_reg == imh_pkg::OP_GET)
                begin
                    ovr_valid = 1'b1;
                    ovr_state = imh_pkg::S_OUT;
                end
                else
                begin
                    ovr_valid = 1'b1;
                    ovr_state = imh_pkg::S_MOVE;
                    k_we = 1'b1;
                    k_waddr = KW'(s_rdata[imh_pkg::KEY_W-1:0]);
                    k_wdata = '0;
                end
            end
            imh_pkg::S_MOVE:
            begin
                // last entry on the read port, move it into cur
                cnt_next = cnt_reg - CW'(1);
                ovr_valid = 1'b1;
                if (cur_reg < last_slot)
                begin
                    s_we = 1'b1; s_waddr = cur_reg; s_wdata = s_rdata;
                    k_we = 1'b1; k_waddr = KW'(s_rdata[imh_pkg::KEY_W-1:0]);
                    k_wdata = {1'b1, cur_reg};
                    ca_next = s_rdata;
                    // decide direction: read parent first
                    ovr_state = imh_pkg::S_UP_RD;
                    pushing_next = 1'b0;
                end
                else
                    ovr_state = imh_pkg::S_PUSH_CHK;
            end
            imh_pkg::S_PUSH_CHK:
            begin
                // after a removal or a climb: an update not yet inserted continues into push, everything else finishes
                ovr_valid = 1'b1;
                if (kind_reg == imh_pkg::OP_UPDATE && !ins_reg)
                begin
                    k_raddr = ikey_i;
                    ovr_state = imh_pkg::S_PUSH_CHK_W;
                end
                else
                    ovr_state = imh_pkg::S_OUT;
            end
            imh_pkg::S_PUSH_CHK_W:
            begin
                ovr_valid = 1'b1;
                if (k_rdata[SW])
                begin
                    status_next = imh_pkg::ST_DUPLICATE;
                    ovr_state = imh_pkg::S_OUT;
                end
                else if (32'(cnt_reg) >= CAPACITY)
                begin
                    status_next = imh_pkg::ST_FULL;
                    ovr_state = imh_pkg::S_OUT;
                end
                else
                begin
                    cur_next = SW'(cnt_reg);
                    ca_next  = {iprio_reg, ikey_reg};
                    ovr_state = imh_pkg::S_PUSH_WR;
                end
            end
            imh_pkg::S_PUSH_WR:
            begin
                s_we = 1'b1; s_waddr = cur_reg; s_wdata = ca_reg;
                k_we = 1'b1; k_waddr = ikey_i; k_wdata = {1'b1, cur_reg};
                cnt_next = cnt_reg + CW'(1);
                pushing_next = 1'b1;
                ins_next = 1'b1;
                ovr_valid = 1'b1;
                ovr_state = imh_pkg::S_UP_RD;
            end
            imh_pkg::S_UP_RD:
            begin
                // ca holds the entry at cur; fetch its parent
                s_raddr = par_slot;
                ovr_valid = 1'b1;
                if (cur_reg == '0)
                    ovr_state = pushing_reg ? imh_pkg::S_PUSH_CHK : imh_pkg::S_DN_RD;
                else
                    ovr_state = imh_pkg::S_UP_W;
            end
            imh_pkg::S_UP_W:
            begin
                ovr_valid = 1'b1;
                if (imh_pkg::ranks_below(pc, pa))
                begin
                    // swap parent and cur
                    s_we = 1'b1; s_waddr = cur_reg; s_wdata = s_rdata;
                    k_we = 1'b1; k_waddr = KW'(s_rdata[imh_pkg::KEY_W-1:0]);
                    k_wdata = {1'b1, cur_reg};
                    cur_next = par_slot;
                    pushing_next = 1'b1;
                    ovr_state = imh_pkg::S_SWAP2;
                end
                else
                    ovr_state = pushing_reg ? imh_pkg::S_PUSH_CHK : imh_pkg::S_DN_RD;
            end
            imh_pkg::S_DN_RD:
            begin
                s_raddr = SW'(lchild);
                ovr_valid = 1'b1;
                ovr_state = (32'(lchild) < 32'(cnt_reg)) ? imh_pkg::S_DN_RD2
                                                         : imh_pkg::S_PUSH_CHK;
            end
            imh_pkg::S_DN_RD2:
            begin
                cb_next = s_rdata;
                s_raddr = SW'(rchild);
                ovr_valid = 1'b1;
                ovr_state = imh_pkg::S_DN_W;
            end
            imh_pkg::S_DN_W:
            begin
                lb = imh_pkg::ranks_below(pa, pb);
                rb = (32'(rchild) < 32'(cnt_reg)) && imh_pkg::ranks_below(pa, pc);
                ovr_valid = 1'b1;
                if (lb || rb)
                begin
                    if (rb && (!lb || imh_pkg::ranks_below(pb, pc)))
                    begin
                        s_we = 1'b1; s_waddr = cur_reg; s_wdata = s_rdata;
                        k_we = 1'b1; k_waddr = KW'(s_rdata[imh_pkg::KEY_W-1:0]);
                        k_wdata = {1'b1, cur_reg};
                        cur_next = SW'(rchild);
                    end
                    else
                    begin
                        s_we = 1'b1; s_waddr = cur_reg; s_wdata = cb_reg;
                        k_we = 1'b1; k_waddr = KW'(cb_reg[imh_pkg::KEY_W-1:0]);
                        k_wdata = {1'b1, cur_reg};
                        cur_next = SW'(lchild);
                    end
                    pushing_next = 1'b0;
                    ovr_state = imh_pkg::S_SWAP2;
                end
                else
                    ovr_state = imh_pkg::S_PUSH_CHK;
            end
            imh_pkg::S_SWAP2:
            begin
                // carried entry goes to its new slot
                s_we = 1'b1; s_waddr = cur_reg; s_wdata = ca_reg;
                k_we = 1'b1; k_waddr = KW'(ca_reg[imh_pkg::KEY_W-1:0]);
                k_wdata = {1'b1, cur_reg};
                ovr_valid = 1'b1;
                ovr_state = pushing_reg ? imh_pkg::S_UP_RD : imh_pkg::S_DN_RD;
            end
            imh_pkg::S_OUT: ;
            default: ;
        endcase
    end

    // output packing
    always_comb
    begin
        m_axis_tvalid = res_valid_reg;
        m_axis_tdata  = res_reg;
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imh_pkg::S_IDLE;
            cnt_reg       <= '0;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            pushing_reg   <= 1'b0;
            ins_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pushing_reg <= pushing_next;
            ins_reg     <= ins_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + (KW+1)'(1);
                if (32'(clr_cnt_reg) == KEY_SPACE - 1)
                    clr_reg <= 1'b0;
            end
            if (state_reg == imh_pkg::S_OUT)
                res_valid_reg <= 1'b1;
            else if (m_axis_tready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        oent_reg   <= oent_next;
        cur_reg    <= cur_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        if (accept)
        begin
            kind_reg  <= in_kind;
            tkey_reg  <= in_tkey;
            ikey_reg  <= in_ikey;
            iprio_reg <= {s_axis_tdata[54:23], s_axis_tdata[86:55]};
        end
        if (state_reg == imh_pkg::S_OUT)
            res_reg <= {cnt_reg, oent_reg[imh_pkg::PRIO_W-1+imh_pkg::KEY_W:imh_pkg::KEY_W],
                        oent_reg[EW-1:imh_pkg::PRIO_W+imh_pkg::KEY_W],
                        oent_reg[imh_pkg::KEY_W-1:0], status_reg} & 88'hFF_FFFF_FFFF_FFFF_FFFF_FFFF;
    end

`ifndef ASSERT_OFF
    // no item taken during the clearing pass
    a_no_acc_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s_axis_tready) else $error("item accepted while clearing");
    // count never exceeds capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= CAPACITY) else $error("count above capacity");
    // a result appears only after the output state
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == imh_pkg::S_OUT))
        else $error("result without finished item");
`endif

endmodule

/* sv/imh_ram.sv */
// generic synchronous ram, one write and one registered read port
// no dependencies

module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

/* verif/testbench.sv */
// testbench for indexed_min_heap: random and directed heap operations over stream ports
// depends on imh_pkg and the heap rtl; a behavioural heap predicts every result

`timescale 1ns / 1ps

module testbench;

    localparam int CAP  = 1024;
    localparam int KSP  = 1024;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] minor;
        logic signed [31:0] major;
        logic [9:0]         item_key;
        logic [9:0]         target_key;
        logic [2:0]         kind;
    } heap_op_t;

    typedef struct packed {
        logic [10:0]        count;
        logic signed [31:0] minor;
        logic signed [31:0] major;
        logic [9:0]         key;
        logic [2:0]         status;
    } heap_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;

    indexed_min_heap uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    // shadow heap
    logic signed [31:0] h_major [CAP];
    logic signed [31:0] h_minor [CAP];
    logic [9:0]         h_key   [CAP];
    bit                 k_valid [KSP];
    int                 k_slot  [KSP];
    int                 n_entries;

    heap_op_t  pending_ops[$];
    heap_res_t expected_results[$];
    int mismatches = 0;
    int ops_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit timed_out = 1'b0;

    function automatic bit lower_rank(int a, int b);
        if (h_major[a] != h_major[b])
            return h_major[a] > h_major[b];
        return h_minor[a] < h_minor[b];
    endfunction

    function automatic void swap_entries(int a, int b);
        logic signed [31:0] t;
        logic [9:0] tk;
        t = h_major[a]; h_major[a] = h_major[b]; h_major[b] = t;
        t = h_minor[a]; h_minor[a] = h_minor[b]; h_minor[b] = t;
        tk = h_key[a]; h_key[a] = h_key[b]; h_key[b] = tk;
        k_slot[h_key[a]] = a;
        k_slot[h_key[b]] = b;
    endfunction

    function automatic void sift_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!lower_rank(p, i))
                break;
            swap_entries(p, i);
            i = p;
        end
    endfunction

    function automatic void sift_down(int i);
        int l, r, c;
        bit lb, rb;
        forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            lb = (l < n_entries) && lower_rank(i, l);
            rb = (r < n_entries) && lower_rank(i, r);
            if (lb && rb)
                c = lower_rank(l, r) ? r : l;
            else if (lb)
                c = l;
            else if (rb)
                c = r;
            else
                break;
            swap_entries(i, c);
            i = c;
        end
    endfunction

    function automatic void take_slot(int s, ref heap_res_t r);
        int last;
        last = n_entries - 1;
        r.key = h_key[s];
        r.major = h_major[s];
        r.minor = h_minor[s];
        k_valid[h_key[s]] = 1'b0;
        if (s < last) begin
            h_major[s] = h_major[last];
            h_minor[s] = h_minor[last];
            h_key[s] = h_key[last];
            k_slot[h_key[s]] = s;
        end
        n_entries = last;
        if (s < n_entries) begin
            if (s > 0 && lower_rank((s - 1) / 2, s))
                sift_up(s);
            else
                sift_down(s);
        end
    endfunction

    function automatic logic [2:0] insert_entry(heap_op_t op);
        int s;
        if (k_valid[op.item_key])
            return imh_pkg::ST_DUPLICATE;
        if (n_entries >= CAP)
            return imh_pkg::ST_FULL;
        s = n_entries;
        h_major[s] = op.major;
        h_minor[s] = op.minor;
        h_key[s] = op.item_key;
        k_valid[op.item_key] = 1'b1;
        k_slot[op.item_key] = s;
        n_entries = s + 1;
        sift_up(s);
        return imh_pkg::ST_OK;
    endfunction

    // compute the result of one operation and advance the shadow heap
    function automatic heap_res_t heap_apply(heap_op_t op);
        heap_res_t r;
        bit found;
        r = '0;
        r.status = imh_pkg::ST_OK;
        found = k_valid[op.target_key];
        case (op.kind)
            imh_pkg::OP_PUSH:
                r.status = insert_entry(op);
            imh_pkg::OP_POP_TOP:
                if (n_entries == 0)
                    r.status = imh_pkg::ST_EMPTY;
                else
                    take_slot(0, r);
            imh_pkg::OP_POP_KEY:
                if (found)
                    take_slot(k_slot[op.target_key], r);
                else
                    r.status = imh_pkg::ST_NOT_FOUND;
            imh_pkg::OP_GET:
                if (found)
                begin
                    r.key = h_key[k_slot[op.target_key]];
                    r.major = h_major[k_slot[op.target_key]];
                    r.minor = h_minor[k_slot[op.target_key]];
                end
                else
                    r.status = imh_pkg::ST_NOT_FOUND;
            imh_pkg::OP_UPDATE:
                if (!found)
                    r.status = imh_pkg::ST_NOT_FOUND;
                else
                begin
                    take_slot(k_slot[op.target_key], r);
                    r.status = insert_entry(op);
                end
            default: ;
        endcase
        r.count = n_entries[10:0];
        return r;
    endfunction

    // keys drawn from a small pool so lookups hit often
    function automatic logic [9:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 10'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
            default: return 10'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [31:0] pick_prio();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic heap_op_t make_op(logic [2:0] k, logic [9:0] tk, logic [9:0] ik,
                                         logic [31:0] ma, logic [31:0] mi);
        heap_op_t op;
        op.kind = k;
        op.target_key = tk;
        op.item_key = ik;
        op.major = ma;
        op.minor = mi;
        return op;
    endfunction

    // append one item to the driver queue
    function automatic void queue_op(heap_op_t op);
        pending_ops.insert(pending_ops.size(), op);
    endfunction

    // stimulus
    initial
    begin
        int w;
        logic [2:0] k;
        queue_op(make_op(imh_pkg::OP_POP_TOP, '0, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_GET, 10'd5, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_POP_KEY, 10'd1023, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_UPDATE, 10'd3, 10'd3, '0, '0));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd0, 32'h8000_0000, 32'h8000_0000));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd1023, 32'h7fff_ffff, 32'h7fff_ffff));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd0, 32'd1, 32'd1));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd7, 32'd5, 32'd2));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd8, 32'd5, 32'd2));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd9, 32'd5, 32'd9));
        queue_op(make_op(imh_pkg::OP_PUSH, '0, 10'd10, 32'd5, 32'h8000_0000));
        queue_op(make_op(imh_pkg::OP_GET, 10'd1023, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_UPDATE, 10'd7, 10'd9, 32'd0, 32'd0));
        queue_op(make_op(imh_pkg::OP_UPDATE, 10'd8, 10'd8, 32'hffff_ffff, 32'd3));
        queue_op(make_op(3'd5, 10'd8, 10'd8, 32'd1, 32'd1));
        queue_op(make_op(3'd7, 10'h3ff, 10'h3ff, '1, '1));
        queue_op(make_op(imh_pkg::OP_POP_KEY, 10'd10, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_POP_TOP, '0, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_POP_TOP, '0, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_POP_TOP, '0, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_POP_TOP, '0, '0, '0, '0));
        queue_op(make_op(imh_pkg::OP_POP_TOP, '0, '0, '0, '0));
        for (int i = 0; i < 500; i++)
        begin
            w = $urandom_range(0, 99);
            // push-heavy first half grows the heap, later half drains it
            if (w < ((i < 250) ? 45 : 25))
                k = imh_pkg::OP_PUSH;
            else if (w < 60)
                k = imh_pkg::OP_POP_TOP;
            else if (w < 72)
                k = imh_pkg::OP_POP_KEY;
            else if (w < 84)
                k = imh_pkg::OP_GET;
            else if (w < 97)
                k = imh_pkg::OP_UPDATE;
            else
                k = 3'($urandom_range(5, 7));
            queue_op(make_op(k, pick_key(), pick_key(), pick_prio(), pick_prio()));
        end
        stim_done = 1'b1;
    end

    // reset
    initial
    begin
        for (int i = 0; i < KSP; i++)
            k_valid[i] = 1'b0;
        n_entries = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // handshakes seen at the rising edge, used by the driver at the next falling edge
    bit in_acc = 1'b0;
    bit out_acc = 1'b0;
    always @(posedge clk)
    begin
        in_acc  <= s_axis_tvalid && s_axis_tready;
        out_acc <= m_axis_tvalid && m_axis_tready;
    end

    // driver
    int src_gap = 0;
    int dst_gap = 0;
    always @(negedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_acc)
                ;
            else if (src_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pending_ops.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, pending_ops.pop_front()};
                src_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
            // result side waits a drawn number of cycles after each item
            if (out_acc)
            begin
                w = $urandom_range(0, 14);
                dst_gap <= w;
                m_axis_tready <= (w == 0);
            end
            else if (dst_gap > 0)
            begin
                dst_gap <= dst_gap - 1;
                m_axis_tready <= (dst_gap == 1);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        heap_res_t got, want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.insert(expected_results.size(),
                                        heap_apply(heap_op_t'(s_axis_tdata[86:0])));
                ops_sent <= ops_sent + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                got = heap_res_t'(m_axis_tdata[87:0]);
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("mismatch: expected st=%0d key=%0d maj=%0d min=%0d cnt=%0d",
                                want.status, want.key, want.major, want.minor, want.count);
                            $display("          got      st=%0d key=%0d maj=%0d min=%0d cnt=%0d",
                                got.status, got.key, got.major, got.minor, got.count);
                        end
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out <= 1'b1;
        end
    end

    // end of run
    initial
    begin
        wait (rst_n);
        while (!((stim_done && pending_ops.size() == 0 && !s_axis_tvalid
                  && expected_results.size() == 0) || timed_out))
            @(posedge clk);
        if (!timed_out)
            repeat (60) @(posedge clk);
        $display("ran %0d heap operations, checked %0d results", ops_sent, results_seen);
        if (timed_out)
            $display("watchdog expired with %0d results outstanding", expected_results.size());
        if (!timed_out && mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
sv/imh_pkg.sv
sv/imh_ram.sv
sv/indexed_min_heap.sv
verif/testbench.sv
